[rtl/core/split_direct_mapped_tlb_assert.svh]
// Assertion macros used by the translation table controller.
// Depends on nothing; expands to nothing when SYNTHESIS is defined.
`ifndef SPLIT_DIRECT_MAPPED_TLB_ASSERT_SVH
`define SPLIT_DIRECT_MAPPED_TLB_ASSERT_SVH
`ifndef SYNTHESIS
`define TLB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TLB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TLB_ASSERT(lbl, clk, rst, prop, msg)
`define TLB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/core/sdtlb_pkg.sv]
// Types and codes of the split direct-mapped translation table.
// Used by the controller, the datapath and the top level.
package sdtlb_pkg;

  localparam int KIND_W     = 2;
  localparam int CLS_W      = 2;
  localparam int VA_W       = 64;
  localparam int FILL_PPN_W = 52;
  localparam int NUM_CLASSES = 3;

  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FILL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

  localparam logic [CLS_W-1:0] CLS_LOAD  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_STORE = 2'd1;
  localparam logic [CLS_W-1:0] CLS_FETCH = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [CLS_W-1:0]      access_class;
    logic [VA_W-1:0]       virt_addr;
    logic [FILL_PPN_W-1:0] fill_phys_page;
    logic                  fill_allowed;
  } req_t;

  typedef struct packed {
    logic            hit;
    logic [VA_W-1:0] phys_addr;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_t;

  typedef struct packed {
    logic accept;
    logic commit;
    logic sweep;
  } cmd_t;

  typedef struct packed {
    logic flush_all;
    logic sweep_last;
  } sts_t;

endpackage

[rtl/core/split_direct_mapped_tlb.sv]
// Top level of the split direct-mapped translation table.
// Depends on sdtlb_pkg, sdtlb_ctrl and sdtlb_dpath.
//
//   Channel  Signals                  Payload
//   request  req_valid, req_stall     req  (sdtlb_pkg::req_t)
//   result   rsp_valid, rsp_stall     rsp  (sdtlb_pkg::rsp_t)
//
// Every request reads the three entry memories when accepted, then compares tags,
// writes back and loads the result register when it commits.
// A flush of address zero then sweeps the valid bits, one index of all three
// tables per cycle, over all 2^INDEX_BITS indices with the request side stalled.
// After reset the same sweep runs over all 2^INDEX_BITS indices before the first request.
// A stalled result waits in its register; the next request is taken meanwhile
// and holds in evaluation until the register frees.
module split_direct_mapped_tlb #(
  parameter int INDEX_BITS = 12,
  parameter int PAGE_BITS  = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  sdtlb_pkg::req_t  req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output sdtlb_pkg::rsp_t  rsp
);

  sdtlb_pkg::cmd_t cmd;
  sdtlb_pkg::sts_t sts;

  sdtlb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  sdtlb_dpath #(
    .INDEX_BITS (INDEX_BITS),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dpath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

[rtl/core/sdtlb_ctrl.sv]
// Controller of the translation table: sequences accept, commit and clearing sweeps.
// Depends on sdtlb_pkg and split_direct_mapped_tlb_assert.svh.
`include "split_direct_mapped_tlb_assert.svh"
module sdtlb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output sdtlb_pkg::cmd_t   cmd,
  input  sdtlb_pkg::sts_t   sts
);

  sdtlb_pkg::state_t state, state_next;
  logic out_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != sdtlb_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdtlb_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      sdtlb_pkg::ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = sdtlb_pkg::ST_IDLE;
        end
      end
      sdtlb_pkg::ST_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = sdtlb_pkg::ST_EVAL;
        end
      end
      sdtlb_pkg::ST_EVAL: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = sts.flush_all ? sdtlb_pkg::ST_CLEAR : sdtlb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sdtlb_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  `TLB_ASSERT(a_commit_sweep_excl, clk, rst, !(cmd.commit && cmd.sweep), "commit during sweep")
  `TLB_ASSERT_NEXT(a_commit_shows, clk, rst, cmd.commit, rsp_valid, "committed result not shown")
  `TLB_ASSERT_NEXT(a_rsp_held, clk, rst, rsp_valid && rsp_stall && !cmd.commit, rsp_valid, "stalled result dropped")
  `TLB_ASSERT_NEXT(a_accept_eval, clk, rst, cmd.accept, state == sdtlb_pkg::ST_EVAL, "accept not followed by evaluation")

endmodule

[rtl/core/sdtlb_dpath.sv]
// Datapath of the translation table: request register, three entry memories,
// tag compare, clearing counter and result register. Depends on sdtlb_pkg.
module sdtlb_dpath #(
  parameter int INDEX_BITS = 12,
  parameter int PAGE_BITS  = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  sdtlb_pkg::req_t  req,
  output sdtlb_pkg::rsp_t  rsp,
  input  sdtlb_pkg::cmd_t  cmd,
  output sdtlb_pkg::sts_t  sts
);

  localparam int PPN_W = sdtlb_pkg::VA_W - PAGE_BITS;
  localparam int TAG_W = PPN_W - INDEX_BITS;
  localparam int DEPTH = 1 << INDEX_BITS;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [PPN_W-1:0] ppn;
  } entry_t;

  sdtlb_pkg::req_t       req_q;
  entry_t                rd [sdtlb_pkg::NUM_CLASSES];
  logic [sdtlb_pkg::NUM_CLASSES-1:0] match;
  logic [INDEX_BITS-1:0] sweep_cnt;
  logic [INDEX_BITS-1:0] req_idx;
  logic [INDEX_BITS-1:0] in_idx;
  logic [TAG_W-1:0]      req_tag;
  logic                  hit;
  logic [PPN_W-1:0]      ppn_sel;

  assign req_idx = req_q.virt_addr[PAGE_BITS +: INDEX_BITS];
  assign req_tag = req_q.virt_addr[sdtlb_pkg::VA_W-1 : PAGE_BITS+INDEX_BITS];
  assign in_idx  = req.virt_addr[PAGE_BITS +: INDEX_BITS];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= sweep_cnt + 1'b1;
    end
  end

  assign sts.sweep_last = &sweep_cnt;
  assign sts.flush_all  = (req_q.kind == sdtlb_pkg::KIND_FLUSH) && (req_q.virt_addr == '0);

  for (genvar c = 0; c < sdtlb_pkg::NUM_CLASSES; c++) begin : g_class
    entry_t                mem [DEPTH];
    logic                  we;
    entry_t                wdata;
    logic [INDEX_BITS-1:0] waddr;

    assign match[c] = rd[c].valid && (rd[c].tag == req_tag);
    assign waddr    = cmd.sweep ? sweep_cnt : req_idx;

    always_comb begin
      we          = 1'b0;
      wdata.valid = 1'b0;
      wdata.tag   = req_tag;
      wdata.ppn   = req_q.fill_phys_page[PPN_W-1:0];
      if (cmd.sweep) begin
        we = 1'b1;
      end else if (cmd.commit) begin
        if (req_q.kind == sdtlb_pkg::KIND_FILL) begin
          if ((req_q.access_class == sdtlb_pkg::CLS_W'(c)) && req_q.fill_allowed) begin
            we          = 1'b1;
            wdata.valid = 1'b1;
          end
        end else if (req_q.kind == sdtlb_pkg::KIND_FLUSH) begin
          we = match[c];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      if (cmd.accept) begin
        rd[c] <= mem[in_idx];
      end
    end
  end

  always_comb begin
    hit     = 1'b0;
    ppn_sel = rd[0].ppn;
    unique case (req_q.access_class)
      sdtlb_pkg::CLS_LOAD: begin
        hit     = match[0];
        ppn_sel = rd[0].ppn;
      end
      sdtlb_pkg::CLS_STORE: begin
        hit     = match[1];
        ppn_sel = rd[1].ppn;
      end
      sdtlb_pkg::CLS_FETCH: begin
        hit     = match[2];
        ppn_sel = rd[2].ppn;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    if (req_q.kind != sdtlb_pkg::KIND_LOOKUP) begin
      hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.hit       <= hit;
      rsp.phys_addr <= hit ? {ppn_sel, req_q.virt_addr[PAGE_BITS-1:0]} : '0;
    end
  end

endmodule
